// ----- rtl/mwpg_pkg.sv -----
package mwpg_pkg;

    localparam int PHASE_STEPS        = 64;
    localparam int PEAK_AMPLITUDE     = 1000;
    localparam int MAX_PACKET_SAMPLES = 64;

    localparam int PHASE_W   = $clog2(PHASE_STEPS);
    localparam int SAW_TOP   = 1000;
    localparam int SAW_W     = 10;
    localparam int SAMPLE_W  = 15;
    localparam int COUNT_W   = 7;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam int TRI_AMP2  = 2 * PEAK_AMPLITUDE;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_SINE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES   = 2'd1;

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
    } t_job;

    // floor(500 * sin(2*pi*k/64) + 500), exact
    localparam t_sample SINE_TABLE [PHASE_STEPS] = '{
        15'd500, 15'd549, 15'd597, 15'd645, 15'd691, 15'd735, 15'd777, 15'd817,
        15'd853, 15'd886, 15'd915, 15'd940, 15'd961, 15'd978, 15'd990, 15'd997,
        15'd1000, 15'd997, 15'd990, 15'd978, 15'd961, 15'd940, 15'd915, 15'd886,
        15'd853, 15'd817, 15'd777, 15'd735, 15'd691, 15'd645, 15'd597, 15'd549,
        15'd500, 15'd450, 15'd402, 15'd354, 15'd308, 15'd264, 15'd222, 15'd182,
        15'd146, 15'd113, 15'd84, 15'd59, 15'd38, 15'd21, 15'd9, 15'd2,
        15'd0, 15'd2, 15'd9, 15'd21, 15'd38, 15'd59, 15'd84, 15'd113,
        15'd146, 15'd182, 15'd222, 15'd264, 15'd308, 15'd354, 15'd402, 15'd450
    };

endpackage

// ----- rtl/mwpg_if.sv -----
interface mwpg_req_if;
    logic valid;
    logic ready;
    logic packet_request;

    modport source (output valid, output packet_request, input ready);
    modport sink   (input valid, input packet_request, output ready);
endinterface

interface mwpg_smp_if;
    logic                valid;
    logic                ready;
    mwpg_pkg::t_sample   sample_value;
    logic                last_in_packet;

    modport source (output valid, output sample_value, output last_in_packet, input ready);
    modport sink   (input valid, input sample_value, input last_in_packet, output ready);
endinterface

interface mwpg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mwpg_pkg::CFG_IDX_W-1:0]      index;
    logic [mwpg_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/multi_waveform_packet_generator.sv -----
// Packet generator for sine, sawtooth and triangle waveforms. Each request with
// packet_request high queues one packet of samples_per_packet samples (saturated at
// 64; a size of zero and a request of zero produce nothing) in the mode set when the
// request was accepted; the final sample carries last_in_packet. Requests are taken
// one per cycle while the two-entry packet queue has room, so they keep flowing
// while a packet is being played out. The generator emits one sample per cycle from
// its output register while o_smp is ready, and loads the next packet from the queue
// after a packet ends, producing no new sample while it loads. Sine and triangle
// keep independent phases, and the sawtooth level persists, across mode changes.
// Mode 3 emits zero samples and leaves all waveform state untouched.
module multi_waveform_packet_generator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mwpg_req_if.sink   i_req,
    mwpg_cfg_if.sink   i_cfg,
    mwpg_smp_if.source o_smp
);
    import mwpg_pkg::*;

    logic push;
    t_job push_job;
    logic queue_full;
    logic queue_valid;
    logic pop;
    t_job pop_job;

    mwpg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg        (i_cfg),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    mwpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_job   (pop_job)
    );

    mwpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_smp       (o_smp)
    );

endmodule

// ----- rtl/mwpg_front.sv -----
module mwpg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mwpg_req_if.sink       i_req,
    mwpg_cfg_if.sink       i_cfg,
    input  logic           i_queue_full,
    output logic           o_push,
    output mwpg_pkg::t_job o_job
);
    import mwpg_pkg::*;

    logic [MODE_W-1:0]  r_wave_mode;
    logic [COUNT_W-1:0] r_samples;
    logic [COUNT_W-1:0] count_sat;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !i_queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode <= MODE_SINE;
            r_samples   <= COUNT_W'(MAX_PACKET_SAMPLES);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_WAVE_MODE) begin
                r_wave_mode <= i_cfg.data[MODE_W-1:0];
            end else if (i_cfg.index == CFG_SAMPLES) begin
                r_samples <= i_cfg.data[COUNT_W-1:0];
            end
        end
    end

    // saturate oversized packets, drop empty ones and idle requests
    assign count_sat = (r_samples > COUNT_W'(MAX_PACKET_SAMPLES))
                     ? COUNT_W'(MAX_PACKET_SAMPLES) : r_samples;
    assign o_push    = i_req.valid && i_req.ready && i_req.packet_request
                     && (count_sat != '0);
    assign o_job.mode  = r_wave_mode;
    assign o_job.count = count_sat;

endmodule

// ----- rtl/mwpg_queue.sv -----
module mwpg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mwpg_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output mwpg_pkg::t_job o_job
);
    import mwpg_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/mwpg_back.sv -----
module mwpg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  mwpg_pkg::t_job i_job,
    output logic           o_pop,
    mwpg_smp_if.source     o_smp
);
    import mwpg_pkg::*;

    localparam int DIST_W = PHASE_W + 1;

    logic               r_busy;
    logic [MODE_W-1:0]  r_mode;
    logic [COUNT_W-1:0] r_left;
    logic [PHASE_W-1:0] r_sine_phase;
    logic [PHASE_W-1:0] r_tri_phase;
    logic [SAW_W-1:0]   r_ramp;
    logic               r_out_valid;
    t_sample            r_out_sample;
    logic               r_out_last;

    logic               step;
    logic [SAW_W-1:0]   n_ramp;
    logic [PHASE_W-1:0] n_sine_phase;
    logic [PHASE_W-1:0] n_tri_phase;
    logic [DIST_W-1:0]  tri_dist;
    logic [31:0]        tri_prod;
    t_sample            tri_value;
    t_sample            n_sample;

    assign o_pop = !r_busy;
    // advance one sample whenever the output register is free or drains
    assign step  = r_busy && (!r_out_valid || o_smp.ready);

    assign n_ramp       = (r_ramp < SAW_W'(SAW_TOP)) ? r_ramp + 1'b1 : '0;
    assign n_sine_phase = (r_sine_phase == PHASE_W'(PHASE_STEPS - 1)) ? '0
                        : r_sine_phase + 1'b1;
    assign n_tri_phase  = (r_tri_phase == PHASE_W'(PHASE_STEPS - 1)) ? '0
                        : r_tri_phase + 1'b1;

    assign tri_dist  = (r_tri_phase < PHASE_W'(PHASE_STEPS / 2))
                     ? {1'b0, r_tri_phase}
                     : DIST_W'(PHASE_STEPS) - {1'b0, r_tri_phase};
    assign tri_prod  = 32'(TRI_AMP2) * 32'(tri_dist);
    assign tri_value = SAMPLE_W'(tri_prod / PHASE_STEPS);

    always_comb begin
        unique case (r_mode)
            MODE_SINE:     n_sample = SINE_TABLE[r_sine_phase];
            MODE_SAWTOOTH: n_sample = SAMPLE_W'(n_ramp);
            MODE_TRIANGLE: n_sample = tri_value;
            MODE_UNUSED:   n_sample = '0;
            default:       n_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_left       <= '0;
            r_sine_phase <= '0;
            r_tri_phase  <= '0;
            r_ramp       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (!r_busy && i_job_valid) begin
                r_busy <= 1'b1;
                r_left <= i_job.count;
            end else if (step) begin
                r_left <= r_left - 1'b1;
                if (r_left == COUNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
                unique case (r_mode)
                    MODE_SINE:     r_sine_phase <= n_sine_phase;
                    MODE_SAWTOOTH: r_ramp <= n_ramp;
                    MODE_TRIANGLE: r_tri_phase <= n_tri_phase;
                    MODE_UNUSED:   r_ramp <= r_ramp;
                    default:       r_ramp <= r_ramp;
                endcase
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_job_valid) begin
            r_mode <= i_job.mode;
        end
        if (step) begin
            r_out_sample <= n_sample;
            r_out_last   <= (r_left == COUNT_W'(1));
        end
    end

    assign o_smp.valid          = r_out_valid;
    assign o_smp.sample_value   = r_out_sample;
    assign o_smp.last_in_packet = r_out_last;

endmodule

// ----- rtl/mwpg_checker.sv -----
module mwpg_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input mwpg_pkg::t_sample i_sample_value,
    input logic              i_last_in_packet
);
    import mwpg_pkg::*;

    // a stalled sample stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("sample withdrawn while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_sample_value <= SAMPLE_W'(PEAK_AMPLITUDE)))
        else $error("sample above peak amplitude");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("sample offered straight after reset");

    // marker of the final sample holds with its sample under stall
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_last_in_packet))
        else $error("packet end marker changed while stalled");

endmodule

bind multi_waveform_packet_generator mwpg_checker u_mwpg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_smp.valid),
    .i_ready          (o_smp.ready),
    .i_sample_value   (o_smp.sample_value),
    .i_last_in_packet (o_smp.last_in_packet)
);
